[rtl/core/lrs_pkg.sv]
// shared types and constants for the link rate smoother
`default_nettype none

package lrs_pkg;

   // payload widths
   localparam int CMD_W    = 1;
   localparam int SAMPLE_W = 20;
   localparam int RATE_W   = 28;
   localparam int FILL_W   = 6;
   localparam int WEIGHT_W = 9;

   // arithmetic widths
   localparam int FRAC_MAX_BITS = 16;
   localparam int SHIFT_W       = SAMPLE_W + FRAC_MAX_BITS;
   localparam int PROD_W        = WEIGHT_W + RATE_W;
   localparam int SUM_W         = PROD_W + 1;
   localparam int BLEND_SHIFT   = 8;

   localparam logic [RATE_W-1:0]   RATE_MAX   = {RATE_W{1'b1}};
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(256);
   localparam logic [SUM_W-1:0]    ROUND_HALF = SUM_W'(128);

   // default parameter values
   localparam int HISTORY_DEPTH_DEF = 60;
   localparam int FRAC_BITS_DEF     = 8;

   // commands
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_WEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_FLOOR       = 1'b1;

   // register reset values
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(77);
   localparam logic [RATE_W-1:0]   FLOOR_RESET  = RATE_W'(256000);

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [SAMPLE_W-1:0] tx_rate_sample;
      logic [SAMPLE_W-1:0] rx_rate_sample;
   } lrs_req_type;

   typedef struct packed {
      logic [RATE_W-1:0] smoothed_tx;
      logic [RATE_W-1:0] smoothed_rx;
      logic [RATE_W-1:0] history_max;
      logic [FILL_W-1:0] history_fill;
   } lrs_rsp_type;

   // sequencer to lane controls
   typedef struct packed {
      logic clear;   // zero the average
      logic start;   // restart the window maximum
      logic mul;     // form both blend products
      logic upd;     // update the average and write it into the ring
      logic seed;    // load the scaled sample instead of the blend
      logic rd;      // read one ring entry for the maximum walk
   } lrs_lane_ctl_type;

endpackage

`default_nettype wire

[rtl/core/lrs_lane.sv]
// one smoothing lane: moving average, history ring and running maximum
`default_nettype none

module lrs_lane
   import lrs_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lrs_lane_ctl_type      ctl,
   input  wire logic [AW-1:0]         addr,
   input  wire logic [SAMPLE_W-1:0]   sample,
   input  wire logic [WEIGHT_W-1:0]   weight,
   output logic      [RATE_W-1:0]     avg_out,
   output logic      [RATE_W-1:0]     max_out,
   output logic                       avg_zero
);

   logic [RATE_W-1:0] ring_mem [HISTORY_DEPTH];

   logic [RATE_W-1:0] avg_ff, avg_in;
   logic [PROD_W-1:0] prod_new_ff, prod_old_ff;
   logic [RATE_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic [RATE_W-1:0] max_ff;

   logic [SHIFT_W-1:0]  shifted;
   logic [RATE_W-1:0]   scaled;
   logic [WEIGHT_W-1:0] weight_inv;
   logic [SUM_W-1:0]    sum;

   // sample to fixed point, saturating
   assign shifted = SHIFT_W'(sample) << FRAC_BITS;
   assign scaled  = (shifted > SHIFT_W'(RATE_MAX)) ? RATE_MAX : shifted[RATE_W-1:0];

   assign weight_inv = WEIGHT_ONE - weight;
   assign sum = SUM_W'(prod_new_ff) + SUM_W'(prod_old_ff) + ROUND_HALF;
   assign avg_in = ctl.seed ? scaled : sum[BLEND_SHIFT +: RATE_W];

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_new_ff <= PROD_W'(weight) * PROD_W'(scaled);
         prod_old_ff <= PROD_W'(weight_inv) * PROD_W'(avg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
      end else if (ctl.clear) begin
         avg_ff <= '0;
      end else if (ctl.upd) begin
         avg_ff <= avg_in;
      end
   end

   // history ring, one access a cycle
   always_ff @(posedge clock) begin
      if (ctl.upd) begin
         ring_mem[addr] <= avg_in;
      end
      if (ctl.rd) begin
         rd_data_ff <= ring_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         max_ff    <= '0;
      end else begin
         rd_vld_ff <= ctl.rd;
         if (ctl.start) begin
            max_ff <= '0;
         end else if (rd_vld_ff && (rd_data_ff > max_ff)) begin
            max_ff <= rd_data_ff;
         end
      end
   end

   assign avg_out  = avg_ff;
   assign max_out  = max_ff;
   assign avg_zero = (avg_ff == '0);

endmodule

`default_nettype wire

[rtl/core/lrs_merge.sv]
// merge of lane maxima with the floor, and the result register
`default_nettype none

module lrs_merge
   import lrs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire logic [RATE_W-1:0]   rate_floor,
   input  wire logic [RATE_W-1:0]   avg_tx,
   input  wire logic [RATE_W-1:0]   avg_rx,
   input  wire logic [RATE_W-1:0]   max_tx,
   input  wire logic [RATE_W-1:0]   max_rx,
   input  wire logic [FILL_W-1:0]   fill,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output lrs_rsp_type              rsp_data
);

   logic        rsp_valid_ff;
   lrs_rsp_type rsp_data_ff;

   logic [RATE_W-1:0] lane_max;
   logic [RATE_W-1:0] merged_max;

   assign lane_max   = (max_tx > max_rx) ? max_tx : max_rx;
   assign merged_max = (lane_max > rate_floor) ? lane_max : rate_floor;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff.smoothed_tx  <= avg_tx;
         rsp_data_ff.smoothed_rx  <= avg_rx;
         rsp_data_ff.history_max  <= merged_max;
         rsp_data_ff.history_fill <= fill;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/core/link_rate_smoother_window_max.sv]
// top level: link rate smoother with sliding-window maximum
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   lrs_req_type (command, tx and rx samples)
//   rsp_      out        rsp_valid / rsp_stall   lrs_rsp_type (averages, max, fill)
//   csr_      in         csr_we                  csr_index, csr_wdata
//
// a sample item runs through MUL, UPD, SCAN (one read per filled history entry),
// DRAIN and DONE, a clear item goes straight to DONE; the walk over the history
// rings at one entry per cycle on each ring's single memory port sets how long a sample item takes
// one item is in work at a time; req_stall is high until the item is finished
// a finished result sits in the output register and the next item is taken while
// it waits; a new result is held back only while that register is full and stalled
// reset is synchronous: averages, fill and head are zeroed and the registers
// go to their defaults; the ring memories need no clearing pass
`default_nettype none

module link_rate_smoother_window_max_core
   import lrs_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire lrs_req_type           req_data,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lrs_rsp_type                rsp_data,

   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [RATE_W-1:0]     csr_wdata
);

   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = $clog2(HISTORY_DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_UPD   = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]          state_ff, state_in;
   lrs_req_type         req_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [RATE_W-1:0]   floor_ff;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic                seed_ff, seed_in;

   logic                req_take;
   logic                rsp_free;
   logic                rsp_load;
   logic [WEIGHT_W-1:0] weight_eff;
   logic [AW-1:0]       lane_addr;
   lrs_lane_ctl_type    lane_ctl;

   logic [RATE_W-1:0]   avg_tx, avg_rx, max_tx, max_rx;
   logic                tx_avg_zero;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid || !rsp_stall;

   // weights above one count as one
   assign weight_eff = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
         floor_ff  <= FLOOR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SMOOTHING_WEIGHT: weight_ff <= csr_wdata[WEIGHT_W-1:0];
            CSR_RATE_FLOOR:       floor_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      seed_in   = seed_ff;
      lane_ctl  = '0;
      lane_addr = scan_ff;
      rsp_load  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               lane_ctl.start = 1'b1;
               if (req_data.command == CMD_CLEAR) begin
                  // clear zeroes averages and ring bookkeeping, result shows the floor
                  lane_ctl.clear = 1'b1;
                  head_in  = '0;
                  count_in = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            // a zero tx average seeds both lanes with the scaled sample
            lane_ctl.mul = 1'b1;
            seed_in  = tx_avg_zero;
            state_in = S_UPD;
         end
         S_UPD: begin
            lane_ctl.upd  = 1'b1;
            lane_ctl.seed = seed_ff;
            lane_addr = head_ff;
            head_in   = (head_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + AW'(1);
            count_in  = (count_ff == CW'(HISTORY_DEPTH)) ? count_ff : count_ff + CW'(1);
            scan_in   = '0;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            // entries 0 .. fill-1 are the ones written since the last clear
            lane_ctl.rd = 1'b1;
            lane_addr = scan_ff;
            if (CW'(scan_ff) == count_ff - CW'(1)) begin
               state_in = S_DRAIN;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            // last read word lands in the running maximum
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         scan_ff  <= '0;
         seed_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
         seed_ff  <= seed_in;
      end
   end

   // held item: lanes read the samples from here
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   lrs_lane #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .FRAC_BITS     (FRAC_BITS)
   ) u_lane_tx (
      .clock    (clock),
      .reset    (reset),
      .ctl      (lane_ctl),
      .addr     (lane_addr),
      .sample   (req_ff.tx_rate_sample),
      .weight   (weight_eff),
      .avg_out  (avg_tx),
      .max_out  (max_tx),
      .avg_zero (tx_avg_zero)
   );

   lrs_lane #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .FRAC_BITS     (FRAC_BITS)
   ) u_lane_rx (
      .clock    (clock),
      .reset    (reset),
      .ctl      (lane_ctl),
      .addr     (lane_addr),
      .sample   (req_ff.rx_rate_sample),
      .weight   (weight_eff),
      .avg_out  (avg_rx),
      .max_out  (max_rx),
      .avg_zero ()
   );

   lrs_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (rsp_load),
      .rate_floor (floor_ff),
      .avg_tx     (avg_tx),
      .avg_rx     (avg_rx),
      .max_tx     (max_tx),
      .max_rx     (max_rx),
      .fill       (FILL_W'(count_ff)),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   // fill never passes the ring depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HISTORY_DEPTH))
      else $error("history fill above ring depth");

   // until the ring wraps, the head sits right after the last filled entry
   a_head_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (count_ff < CW'(HISTORY_DEPTH)) |-> (CW'(head_ff) == count_ff))
      else $error("ring head out of step with fill");

   // the walk only touches written entries
   a_scan_in_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (CW'(scan_ff) < count_ff))
      else $error("maximum walk beyond filled entries");

   // a result is only loaded into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("result loaded over a waiting item");

endmodule

`default_nettype wire
